@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the grid cell neighborhood unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define GCNE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define GCNE_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define GCNE_ASSERT(name, prop)
`define GCNE_ASSERT_NEVER(name, cond)
`endif

`endif

@@ rtl/core/gcne_pkg.sv @@
// Shared constants and types of the grid cell neighborhood unit.
`timescale 1ns / 1ps
package gcne_pkg;

  localparam int unsigned MAX_CELLS_PER_AXIS = 64;
  localparam int unsigned COORD_BITS_DEF     = 16;
  localparam int unsigned ORIGIN_W           = 16;
  localparam int unsigned SIZE_W             = 13;
  localparam int unsigned CNT_W              = 7;
  localparam int unsigned IDX_W              = 6;
  localparam int unsigned OUT_TDATA_W        = 16;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned CFG_DATA_W         = 16;
  localparam int unsigned FIFO_DEPTH         = 2;

  localparam logic [1:0] RADIUS_WIDE   = 2'd2;
  localparam logic [1:0] RADIUS_NARROW = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_CELL_WIDTH   = 3'd2,
    REG_CELL_HEIGHT  = 3'd3,
    REG_CELLS_ACROSS = 3'd4,
    REG_CELLS_DOWN   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [SIZE_W-1:0]   cell_w;
    logic [SIZE_W-1:0]   cell_h;
    logic [CNT_W-1:0]    n_across;
    logic [CNT_W-1:0]    n_down;
  } grid_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_hi;
    logic [IDX_W-1:0] row_lo;
    logic [IDX_W-1:0] col_lo;
    logic [IDX_W-1:0] col_hi;
  } span_t;

endpackage

@@ rtl/core/grid_cell_neighbourhood_enumerator_unit.sv @@
// Top level of the grid cell neighborhood unit with its configuration registers.
// Each request carries a position and a mode bit; the unit finds the grid cell of the
// position and returns every in-grid cell of its 3x3 or 5x5 neighborhood, rows from
// the highest down, columns from the lowest up, with tlast on the final cell. A grid
// with no rows or no columns returns nothing. For each request the front end loads the
// dividers, divides both axes at once bit by bit, forms the span and hands it off; the
// back end sends one cell per cycle while the receiver is ready, so a request occupies
// the unit for the longer of the front-end work and the sending of its cells. A
// two-entry span queue lets the front end work on the next request while the back
// end is still sending cells. Registers may only be written while the unit is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module grid_cell_neighbourhood_enumerator_unit import gcne_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned S_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [S_TDATA_W-1:0]   s_axis_tdata_i,   // pos_x, pos_y
  input  logic [0:0]             s_axis_tuser_i,   // wide_mode
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // cell_row, cell_col
  output logic                   m_axis_tlast_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [ORIGIN_W-1:0] origin_x_q, origin_y_q;
  logic [SIZE_W-1:0]   cell_w_q, cell_h_q;
  logic [CNT_W-1:0]    across_q, down_q;
  grid_cfg_t           grid_cfg;
  logic                cfg_we;

  logic             push, fifo_full, fifo_valid, pop;
  span_t            span_in, span_out;
  logic [IDX_W-1:0] cell_row, cell_col;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      cell_w_q   <= SIZE_W'(64);
      cell_h_q   <= SIZE_W'(64);
      across_q   <= CNT_W'(64);
      down_q     <= CNT_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ORIGIN_X:     origin_x_q <= cfg_data_i[ORIGIN_W-1:0];
        REG_ORIGIN_Y:     origin_y_q <= cfg_data_i[ORIGIN_W-1:0];
        REG_CELL_WIDTH:   cell_w_q   <= cfg_data_i[SIZE_W-1:0];
        REG_CELL_HEIGHT:  cell_h_q   <= cfg_data_i[SIZE_W-1:0];
        REG_CELLS_ACROSS: across_q   <= cfg_data_i[CNT_W-1:0];
        REG_CELLS_DOWN:   down_q     <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    grid_cfg.origin_x = origin_x_q;
    grid_cfg.origin_y = origin_y_q;
    grid_cfg.cell_w   = (cell_w_q == '0) ? SIZE_W'(1) : cell_w_q;
    grid_cfg.cell_h   = (cell_h_q == '0) ? SIZE_W'(1) : cell_h_q;
    grid_cfg.n_across = (across_q > CNT_W'(MAX_CELLS_PER_AXIS)) ?
                        CNT_W'(MAX_CELLS_PER_AXIS) : across_q;
    grid_cfg.n_down   = (down_q > CNT_W'(MAX_CELLS_PER_AXIS)) ?
                        CNT_W'(MAX_CELLS_PER_AXIS) : down_q;
  end

  gcne_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (grid_cfg),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .pos_x_i   (s_axis_tdata_i[COORD_BITS-1:0]),
    .pos_y_i   (s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .wide_i    (s_axis_tuser_i[0]),
    .push_o    (push),
    .span_o    (span_in),
    .full_i    (fifo_full)
  );

  gcne_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (span_in),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (span_out)
  );

  gcne_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (fifo_valid),
    .data_i    (span_out),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .row_o     (cell_row),
    .col_o     (cell_col),
    .last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'({cell_col, cell_row});

  `GCNE_ASSERT(a_push_not_full, push |-> !fifo_full)
  `GCNE_ASSERT(a_rows_ordered, push |-> (span_in.row_lo <= span_in.row_hi))
  `GCNE_ASSERT(a_cols_ordered, push |-> (span_in.col_lo <= span_in.col_hi))
  `GCNE_ASSERT_NEVER(a_pop_empty, pop && !fifo_valid)

endmodule

@@ rtl/core/gcne_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module gcne_div import gcne_pkg::*; #(
  parameter int unsigned DW = COORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DW-1:0]     dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DW-1:0]     quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] dvs_q, dvs_d;
  logic [DW-1:0]     dq_q, dq_d;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   trial_sub;
  logic              ge;

  assign trial     = {rem_q, dq_q[DW-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dq_d   = dq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      rem_d  = '0;
      dvs_d  = divisor_i;
      dq_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[SIZE_W-1:0] : trial[SIZE_W-1:0];
      dq_d  = {dq_q[DW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dq_q  <= dq_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

@@ rtl/core/gcne_front.sv @@
// Front end: takes requests, finds the grid cell and the clamped neighborhood span.
`timescale 1ns / 1ps
module gcne_front import gcne_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  grid_cfg_t             cfg_i,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic                  wide_i,
  output logic                  push_o,
  output span_t                 span_o,
  input  logic                  full_i
);

  localparam int unsigned DW = ((COORD_BITS > ORIGIN_W) ? COORD_BITS : ORIGIN_W) + 1;
  localparam int unsigned QW = DW - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } front_state_e;

  typedef struct packed {
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] lo;
  } axis_span_t;

  function automatic axis_span_t axis_span(input logic [QW-1:0] q,
                                           input logic [CNT_W-1:0] n,
                                           input logic [1:0] r);
    logic [CNT_W-1:0] lim;
    logic [IDX_W-1:0] c;
    logic [IDX_W:0]   up;
    axis_span_t       s;
    lim  = n - 1'b1;
    c    = (q >= QW'(n)) ? IDX_W'(lim) : q[IDX_W-1:0];
    up   = {1'b0, c} + (IDX_W + 1)'(r);
    s.hi = (up > (IDX_W + 1)'(lim)) ? IDX_W'(lim) : up[IDX_W-1:0];
    s.lo = (c >= IDX_W'(r)) ? c - IDX_W'(r) : '0;
    return s;
  endfunction

  front_state_e state_q, state_d;
  logic         in_full_q, in_full_d;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic         wide_q, wide_run_q;
  span_t        span_q, span_d;

  logic             accept, take, grid_empty, div_start;
  logic signed [DW-1:0] diff_x, diff_y;
  logic [QW-1:0]    dvd_x, dvd_y, quo_x, quo_y;
  logic [SIZE_W-1:0] dvs_x, dvs_y;
  logic             done_x, done_y;
  logic [1:0]       radius;
  axis_span_t       sx, sy;

  assign s_ready_o  = !in_full_q;
  assign accept     = s_valid_i && s_ready_o;
  assign take       = (state_q == ST_IDLE) && in_full_q;
  assign grid_empty = (cfg_i.n_across == '0) || (cfg_i.n_down == '0);
  assign div_start  = take && !grid_empty;

  assign diff_x = DW'(px_q) - DW'($signed(cfg_i.origin_x));
  assign diff_y = DW'(py_q) - DW'($signed(cfg_i.origin_y));
  assign dvd_x  = (diff_x > 0) ? diff_x[QW-1:0] : '0;
  assign dvd_y  = (diff_y > 0) ? diff_y[QW-1:0] : '0;
  assign dvs_x  = cfg_i.cell_w;
  assign dvs_y  = cfg_i.cell_h;

  gcne_div #(.DW(QW)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_x),
    .divisor_i  (dvs_x),
    .done_o     (done_x),
    .quotient_o (quo_x)
  );

  gcne_div #(.DW(QW)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_y),
    .divisor_i  (dvs_y),
    .done_o     (done_y),
    .quotient_o (quo_y)
  );

  assign radius = wide_run_q ? RADIUS_WIDE : RADIUS_NARROW;
  assign sx     = axis_span(quo_x, cfg_i.n_across, radius);
  assign sy     = axis_span(quo_y, cfg_i.n_down, radius);
  assign push_o = (state_q == ST_PUSH) && !full_i;
  assign span_o = span_q;

  always_comb begin
    state_d   = state_q;
    span_d    = span_q;
    in_full_d = in_full_q;
    if (accept) begin
      in_full_d = 1'b1;
    end else if (take) begin
      in_full_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (div_start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (done_x && done_y) begin
          span_d.row_hi = sy.hi;
          span_d.row_lo = sy.lo;
          span_d.col_lo = sx.lo;
          span_d.col_hi = sx.hi;
          state_d       = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_full_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_full_q <= in_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q <= span_d;
    if (accept) begin
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      wide_q <= wide_i;
    end
    if (take) begin
      wide_run_q <= wide_q;
    end
  end

endmodule

@@ rtl/core/gcne_fifo.sv @@
// Short queue of neighborhood spans between the front and the back end.
`timescale 1ns / 1ps
module gcne_fifo import gcne_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  span_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output span_t data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  span_t         mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = count_q == CW'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/gcne_back.sv @@
// Back end: walks each span row by row and sends one cell per cycle while the receiver is ready.
`timescale 1ns / 1ps
module gcne_back import gcne_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  span_t            data_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [IDX_W-1:0] row_o,
  output logic [IDX_W-1:0] col_o,
  output logic             last_o
);

  logic             active_q, active_d;
  span_t            span_q, span_d;
  logic [IDX_W-1:0] row_q, row_d, col_q, col_d;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_row_q, out_row_d, out_col_q, out_col_d;
  logic             out_last_q, out_last_d;
  logic             adv, emit, is_last, need_load;

  assign is_last   = (row_q == span_q.row_lo) && (col_q == span_q.col_hi);
  assign adv       = !out_valid_q || m_ready_i;
  assign emit      = adv && active_q;
  assign need_load = !active_q || (emit && is_last);
  assign pop_o     = need_load && valid_i;

  always_comb begin
    active_d    = active_q;
    span_d      = span_q;
    row_d       = row_q;
    col_d       = col_q;
    out_valid_d = out_valid_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_last_d  = out_last_q;
    if (adv) begin
      out_valid_d = active_q;
    end
    if (emit) begin
      out_row_d  = row_q;
      out_col_d  = col_q;
      out_last_d = is_last;
    end
    if (pop_o) begin
      active_d = 1'b1;
      span_d   = data_i;
      row_d    = data_i.row_hi;
      col_d    = data_i.col_lo;
    end else if (need_load) begin
      active_d = 1'b0;
    end else if (emit) begin
      if (col_q == span_q.col_hi) begin
        col_d = span_q.col_lo;
        row_d = row_q - 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q     <= span_d;
    row_q      <= row_d;
    col_q      <= col_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_last_q <= out_last_d;
  end

  assign m_valid_o = out_valid_q;
  assign row_o     = out_row_q;
  assign col_o     = out_col_q;
  assign last_o    = out_last_q;

endmodule

@@ dv/gcne_cell_checker.sv @@
// Checker for the grid cell neighborhood unit: tracks registers, predicts cells, compares.
`timescale 1ns / 1ps
module gcne_cell_checker import gcne_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [2*ORIGIN_W-1:0]  s_tdata_i,   // pos_x, pos_y
  input  logic [0:0]             s_tuser_i,   // wide_mode
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,   // cell_row, cell_col
  input  logic                   m_tlast_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } cell_t;

  cell_t               cell_queue[$];
  logic [ORIGIN_W-1:0] origin_x_q;
  logic [ORIGIN_W-1:0] origin_y_q;
  logic [SIZE_W-1:0]   cell_w_q;
  logic [SIZE_W-1:0]   cell_h_q;
  logic [CNT_W-1:0]    across_q;
  logic [CNT_W-1:0]    down_q;
  int                  fails;

  assign fail_count_o = fails;

  function automatic int axis_count(logic [CNT_W-1:0] n);
    return (int'(n) > int'(MAX_CELLS_PER_AXIS)) ? int'(MAX_CELLS_PER_AXIS) : int'(n);
  endfunction

  function automatic int axis_cell(int diff, logic [SIZE_W-1:0] size, int n);
    int span;
    int q;
    span = (size == '0) ? 1 : int'(size);
    q = (diff <= 0) ? 0 : diff / span;
    if (q >= n) begin
      q = n - 1;
    end
    return q;
  endfunction

  function automatic void queue_neighbours(logic [ORIGIN_W-1:0] px, logic [ORIGIN_W-1:0] py,
                                           logic wide);
    int    n_across;
    int    n_down;
    int    pos_v;
    int    org_v;
    int    row;
    int    col;
    int    rad;
    int    dy;
    int    dx;
    int    total;
    cell_t found[25];
    n_across = axis_count(across_q);
    n_down = axis_count(down_q);
    total = 0;
    if (n_across == 0 || n_down == 0) begin
      return;
    end
    pos_v = $signed(py);
    org_v = $signed(origin_y_q);
    row = axis_cell(pos_v - org_v, cell_h_q, n_down);
    pos_v = $signed(px);
    org_v = $signed(origin_x_q);
    col = axis_cell(pos_v - org_v, cell_w_q, n_across);
    rad = wide ? int'(RADIUS_WIDE) : int'(RADIUS_NARROW);
    for (dy = rad; dy >= -rad; dy--) begin
      for (dx = -rad; dx <= rad; dx++) begin
        if (row + dy >= 0 && row + dy < n_down && col + dx >= 0 && col + dx < n_across) begin
          found[total].row = IDX_W'(row + dy);
          found[total].col = IDX_W'(col + dx);
          found[total].last = 1'b0;
          total++;
        end
      end
    end
    for (int i = 0; i < total; i++) begin
      found[i].last = (i == total - 1);
      cell_queue.insert(cell_queue.size(), found[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cell_t want;
    if (!rst_ni) begin
      origin_x_q = '0;
      origin_y_q = '0;
      cell_w_q = SIZE_W'(64);
      cell_h_q = SIZE_W'(64);
      across_q = CNT_W'(64);
      down_q = CNT_W'(64);
      cell_queue.delete();
      fails = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (cell_queue.size() == 0) begin
          $error("unexpected cell: row %0d, col %0d, last %0b",
                 m_tdata_i[IDX_W-1:0], m_tdata_i[2*IDX_W-1:IDX_W], m_tlast_i);
          fails++;
        end else begin
          want = cell_queue.pop_front();
          if (m_tdata_i[IDX_W-1:0] !== want.row) begin
            $error("cell_row: expected %0d, actual %0d", want.row, m_tdata_i[IDX_W-1:0]);
            fails++;
          end
          if (m_tdata_i[2*IDX_W-1:IDX_W] !== want.col) begin
            $error("cell_col: expected %0d, actual %0d", want.col,
                   m_tdata_i[2*IDX_W-1:IDX_W]);
            fails++;
          end
          if (m_tlast_i !== want.last) begin
            $error("last_cell: expected %0b, actual %0b", want.last, m_tlast_i);
            fails++;
          end
          if (m_tdata_i[OUT_TDATA_W-1:2*IDX_W] !== '0) begin
            $error("tdata padding: expected 0, actual %0h", m_tdata_i[OUT_TDATA_W-1:2*IDX_W]);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        queue_neighbours(s_tdata_i[ORIGIN_W-1:0], s_tdata_i[2*ORIGIN_W-1:ORIGIN_W],
                         s_tuser_i[0]);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ORIGIN_X:     origin_x_q = cfg_data_i[ORIGIN_W-1:0];
          REG_ORIGIN_Y:     origin_y_q = cfg_data_i[ORIGIN_W-1:0];
          REG_CELL_WIDTH:   cell_w_q = cfg_data_i[SIZE_W-1:0];
          REG_CELL_HEIGHT:  cell_h_q = cfg_data_i[SIZE_W-1:0];
          REG_CELLS_ACROSS: across_q = cfg_data_i[CNT_W-1:0];
          REG_CELLS_DOWN:   down_q = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = cell_queue.size();
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for the grid cell neighborhood unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb import gcne_pkg::*;;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_TAIL = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [2*ORIGIN_W-1:0]  s_tdata;
  logic [0:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic                   in_taken = 1'b0;
  logic                   cfg_taken = 1'b0;
  int                     stuck_cycles = 0;
  bit                     hold_off_req = 1'b0;
  int                     fail_count;
  int                     pending;
  int                     burst_left;
  int                     gap_max;

  logic [ORIGIN_W-1:0]    grid_ox;
  logic [ORIGIN_W-1:0]    grid_oy;
  logic [SIZE_W-1:0]      grid_cw;
  logic [SIZE_W-1:0]      grid_ch;
  logic [CNT_W-1:0]       grid_na;
  logic [CNT_W-1:0]       grid_nd;

  grid_cell_neighbourhood_enumerator_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  gcne_cell_checker cell_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_taken <= s_tvalid && s_tready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver switches between stall patterns and honors one long hold-off on request.
  initial begin : receiver
    int style;
    int style_left;
    style = 0;
    style_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(10, 80);
      end
      style_left--;
      case (style)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_query(input logic [ORIGIN_W-1:0] px, input logic [ORIGIN_W-1:0] py,
                            input logic wide);
    s_tvalid <= 1'b1;
    s_tdata <= {py, px};
    s_tuser <= wide;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
  endtask

  task automatic offer_query(input logic [ORIGIN_W-1:0] px, input logic [ORIGIN_W-1:0] py,
                             input logic wide);
    send_query(px, py, wide);
    if (burst_left > 0 || gap_max == 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      s_tdata <= $urandom;
      s_tuser <= 1'($urandom);
      repeat ($urandom_range(1, gap_max)) @(negedge clk);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // A query on an empty grid returns nothing but may still be in flight.
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= CFG_DATA_W'($urandom);
    @(negedge clk);
  endtask

  task automatic load_grid(input logic [CFG_DATA_W-1:0] ox, input logic [CFG_DATA_W-1:0] oy,
                           input logic [CFG_DATA_W-1:0] cw, input logic [CFG_DATA_W-1:0] ch,
                           input logic [CFG_DATA_W-1:0] na, input logic [CFG_DATA_W-1:0] nd);
    wait_drain();
    grid_ox = ox;
    grid_oy = oy;
    grid_cw = cw[SIZE_W-1:0];
    grid_ch = ch[SIZE_W-1:0];
    grid_na = na[CNT_W-1:0];
    grid_nd = nd[CNT_W-1:0];
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_CELL_WIDTH, cw);
    write_reg(REG_CELL_HEIGHT, ch);
    write_reg(REG_CELLS_ACROSS, na);
    write_reg(REG_CELLS_DOWN, nd);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd4096;
      2:       return 16'd8191;
      3:       return 16'd1;
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return 16'd1;
      1:       return 16'($urandom_range(65, 127));
      2:       return 16'd64;
      default: return 16'($urandom_range(2, 63));
    endcase
  endfunction

  // A coordinate near the grid along one axis, a cell or so beyond either edge.
  function automatic logic [ORIGIN_W-1:0] near_pos(logic [ORIGIN_W-1:0] origin,
                                                   logic [SIZE_W-1:0] size,
                                                   logic [CNT_W-1:0] count);
    int span;
    int reach;
    span = (size == '0) ? 1 : int'(size);
    reach = span * (int'(count) + 2);
    return ORIGIN_W'(int'(origin) + int'($urandom_range(0, reach)) - span);
  endfunction

  initial begin
    int phase;
    rst_n = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ORIGIN_X;
    cfg_data = '0;
    burst_left = 0;
    gap_max = 4;
    grid_ox = '0;
    grid_oy = '0;
    grid_cw = SIZE_W'(64);
    grid_ch = SIZE_W'(64);
    grid_na = CNT_W'(64);
    grid_nd = CNT_W'(64);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Grid as it comes out of reset: corners, clamping on both sides, interior cells.
    offer_query(16'd0, 16'd0, 1'b0);
    offer_query(16'd0, 16'd0, 1'b1);
    offer_query(16'h8000, 16'h8000, 1'b1);
    offer_query(16'h7fff, 16'h7fff, 1'b1);
    offer_query(16'h7fff, 16'h8000, 1'b0);
    offer_query(16'h8000, 16'h7fff, 1'b0);
    offer_query(16'd645, 16'd1280, 1'b1);
    offer_query(16'd640, 16'd1343, 1'b0);
    offer_query(16'd4032, 16'd64, 1'b1);

    // Extreme origins, zero width treated as one, oversized column count, single row.
    load_grid(16'h8000, 16'h7fff, 16'd0, 16'd4096, 16'd127, 16'd1);
    offer_query(16'h8000, 16'h7fff, 1'b1);
    offer_query(16'h7fff, 16'h7fff, 1'b1);
    offer_query(16'h8020, 16'h8000, 1'b0);
    offer_query(16'hffff, 16'h0000, 1'b1);

    load_grid(-16'sd100, 16'd250, 16'd8191, 16'd0, 16'd1, 16'd65);
    offer_query(16'd8091, 16'd250, 1'b1);
    offer_query(-16'sd100, 16'd313, 1'b0);
    offer_query(16'd0, 16'h7fff, 1'b1);

    // Grids with no columns or no rows return nothing.
    load_grid(16'd0, 16'd0, 16'd16, 16'd16, 16'd0, 16'd5);
    offer_query(16'd5, 16'd5, 1'b1);
    offer_query(16'd100, 16'd0, 1'b0);
    load_grid(16'd0, 16'd0, 16'd16, 16'd16, 16'd5, 16'd0);
    offer_query(16'd20, 16'd20, 1'b1);
    wait_drain();
    write_reg(REG_UNUSED, 16'hffff);
    load_grid(16'd0, 16'd0, 16'd16, 16'd16, 16'd3, 16'd2);
    offer_query(16'd20, 16'd20, 1'b1);
    offer_query(16'd40, 16'd0, 1'b0);

    for (phase = 0; phase < 5; phase++) begin
      load_grid(16'($urandom), 16'($urandom), pick_size(), pick_size(), pick_count(),
                pick_count());
      gap_max = (phase == 1 || phase == 2) ? 0 : $urandom_range(2, 20);
      if (phase == 2) begin
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < 24; n++) begin
        if (phase == 3 && n == 12) begin
          wait_drain();
        end
        if ($urandom_range(0, 4) == 0) begin
          offer_query(16'($urandom), 16'($urandom), 1'($urandom));
        end else begin
          offer_query(near_pos(grid_ox, grid_cw, grid_na), near_pos(grid_oy, grid_ch, grid_nd),
                      1'($urandom));
        end
      end
    end

    wait_drain();
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
